>>> sv/tcon_pkg.sv
// Shared types and constants for the text console teletype.
// No dependencies.
package tcon_pkg;

  localparam logic [1:0] KIND_TTY   = 2'd0;
  localparam logic [1:0] KIND_SETC  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_BLANK = 8'h20;

  localparam logic [7:0] DEF_COLS = 8'd80;
  localparam logic [7:0] DEF_ROWS = 8'd25;

  localparam int STRIDE_W = 16;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef logic [15:0] cell_t;

endpackage

>>> sv/tcon_cell_mem.sv
// Cell store: one write port, one read port, registered read data.
// Depends on tcon_pkg for the cell type.
module tcon_cell_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tcon_pkg::cell_t wdata,
  input  logic [AW-1:0]   raddr,
  output tcon_pkg::cell_t rdata
);

  tcon_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/text_console_teletype.sv
// Sequence: a teletype request passes load, cursor move, address and cell, then a scroll
// if needed (rows copied up, bottom row blanked) and done; a read passes load, address,
// cell and done; set cursor reduces both by repeated subtraction, an unused kind goes to done.
// The receiver cannot stall the result. Throughput: one request at a time; busy drops in
// the cycle of the result strobe. Reset: synchronous; then, with busy high, a clearing pass
// zeroes all PAGES*MAX_ROWS*MAX_COLS cells (32768 at defaults). Uses tcon_pkg, tcon_cell_mem.
module text_console_teletype #(
  parameter int PAGES    = 8,
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  glyph,
  input  logic [2:0]  page_sel,
  input  logic [7:0]  attr_in,
  input  logic [7:0]  row_req,
  input  logic [7:0]  col_req,
  output logic        done,
  output logic [7:0]  cursor_row_out,
  output logic [7:0]  cursor_col_out,
  output logic [2:0]  page_out,
  output logic [7:0]  glyph_out,
  output logic [7:0]  attr_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = PAGES * MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SW    = tcon_pkg::STRIDE_W;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_MOVE   = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_ADDR   = 4'd5;
  localparam logic [3:0] S_CELL   = 4'd6;
  localparam logic [3:0] S_SCROLL = 4'd7;
  localparam logic [3:0] S_BLANK  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // configuration registers
  logic [7:0] screen_columns;
  logic [5:0] screen_rows;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= tcon_pkg::DEF_COLS;
      screen_rows    <= 6'(tcon_pkg::DEF_ROWS);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tcon_pkg::REG_COLS: screen_columns <= pwdata[7:0];
        tcon_pkg::REG_ROWS: screen_rows    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tcon_pkg::REG_COLS: prdata = {24'd0, screen_columns};
      tcon_pkg::REG_ROWS: prdata = {26'd0, screen_rows};
      default:            prdata = 32'd0;
    endcase
  end

  // effective screen size: zero means default, clip to the maximum
  logic [7:0] cols_eff, rows_eff, cols_z, rows_z;
  assign cols_z   = (screen_columns == 8'd0) ? tcon_pkg::DEF_COLS : screen_columns;
  assign rows_z   = (screen_rows == 6'd0) ? tcon_pkg::DEF_ROWS : {2'd0, screen_rows};
  assign cols_eff = (32'(cols_z) > MAX_COLS) ? 8'(MAX_COLS) : cols_z;
  assign rows_eff = (32'(rows_z) > MAX_ROWS) ? 8'(MAX_ROWS) : rows_z;

  // per-page state, small enough for flops
  logic [7:0] cur_rows  [PAGES];
  logic [7:0] cur_cols  [PAGES];
  logic [7:0] page_attr [PAGES];
  logic [2:0] shown_page;

  // request and working registers
  logic [3:0]    state;
  logic [1:0]    k;
  logic [7:0]    gl, at;
  logic [2:0]    pgr;
  logic [7:0]    rows, cols;
  logic [7:0]    row_c, col_c, wrow, wcol;
  logic [7:0]    blank_attr;
  logic          wr_cell;
  tcon_pkg::cell_t cell_data;
  logic [SW-1:0] stride, cnt, rowoff;
  logic [AW-1:0] base;
  logic [AW-1:0] clr_cnt;

  logic [PW-1:0] pidx;
  assign pidx = pgr[PW-1:0];

  logic [7:0] st_row, st_col, cl_row, cl_col;
  assign st_row = cur_rows[pidx];
  assign st_col = cur_cols[pidx];
  assign cl_row = (st_row >= rows) ? rows - 8'd1 : st_row;
  assign cl_col = (st_col >= cols) ? cols - 8'd1 : st_col;

  // glyph classes for the cursor move
  logic is_print, bs_left, bs_up;
  assign is_print = (gl != tcon_pkg::CH_CR) && (gl != tcon_pkg::CH_LF) &&
                    (gl != tcon_pkg::CH_BS);
  assign bs_left  = (gl == tcon_pkg::CH_BS) && (col_c != '0);
  assign bs_up    = (gl == tcon_pkg::CH_BS) && (col_c == '0) && (row_c != '0);

  logic [SW-1:0] copy_len;
  assign copy_len = stride - SW'(cols);

  // memory port
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  tcon_pkg::cell_t mem_wdata, mem_rdata;

  tcon_cell_mem #(.DEPTH(DEPTH), .AW(AW)) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  logic [AW-1:0] cell_addr;
  assign cell_addr = AW'(32'(base) + 32'(rowoff) + 32'(wcol));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = cell_data;
    mem_raddr = cell_addr;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_CELL: begin
        mem_we = (k == tcon_pkg::KIND_TTY) && wr_cell;
      end
      S_SCROLL: begin
        // read one row ahead, write back what arrived last cycle
        mem_raddr = AW'(32'(base) + 32'(cnt) + 32'(cols));
        mem_we    = (cnt != '0);
        mem_waddr = AW'(32'(base) + 32'(cnt) - 32'd1);
        mem_wdata = mem_rdata;
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(32'(base) + 32'(cnt));
        mem_wdata = {blank_attr, tcon_pkg::CH_BLANK};
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  logic [7:0] row_fin;
  assign row_fin = (row_c >= rows) ? rows - 8'd1 : row_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      shown_page <= '0;
      done       <= 1'b0;
      for (int i = 0; i < PAGES; i++) begin
        cur_rows[i]  <= '0;
        cur_cols[i]  <= '0;
        page_attr[i] <= '0;
      end
    end else begin
      done <= (state == S_DONE);
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (32'(clr_cnt) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            // latch the request and the screen size
            k    <= kind;
            gl   <= glyph;
            at   <= attr_in;
            rows <= rows_eff;
            cols <= cols_eff;
            if (kind[1]) begin
              pgr <= shown_page;
            end else begin
              pgr        <= 3'(32'(page_sel) % PAGES);
              shown_page <= 3'(32'(page_sel) % PAGES);
            end
            row_c <= row_req;
            col_c <= col_req;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          stride <= SW'(rows) * SW'(cols);
          case (k)
            tcon_pkg::KIND_TTY: begin
              row_c <= cl_row;
              col_c <= cl_col;
              state <= S_MOVE;
            end
            tcon_pkg::KIND_SETC: state <= S_DIV;
            tcon_pkg::KIND_READ: begin
              wrow  <= cl_row;
              wcol  <= cl_col;
              state <= S_ADDR;
            end
            default: state <= S_DONE;
          endcase
        end
        S_MOVE: begin
          // cell to touch: backspace target, or the cursor itself for a printable
          wr_cell    <= (gl == tcon_pkg::CH_BS) || is_print;
          blank_attr <= is_print ? at : page_attr[pidx];
          cell_data  <= is_print ? {at, gl} : {page_attr[pidx], tcon_pkg::CH_BLANK};
          wrow       <= bs_up ? row_c - 8'd1 : row_c;
          wcol       <= bs_left ? col_c - 8'd1 : (bs_up ? cols - 8'd1 : col_c);
          if (gl == tcon_pkg::CH_CR) begin
            col_c <= '0;
          end else if (gl == tcon_pkg::CH_LF) begin
            row_c <= row_c + 8'd1;
          end else if (bs_left) begin
            col_c <= col_c - 8'd1;
          end else if (bs_up) begin
            row_c <= row_c - 8'd1;
            col_c <= cols - 8'd1;
          end else if (is_print) begin
            // printable: its attribute becomes the page attribute
            page_attr[pidx] <= at;
            if (col_c + 8'd1 >= cols) begin
              col_c <= '0;
              row_c <= row_c + 8'd1;
            end else begin
              col_c <= col_c + 8'd1;
            end
          end
          state <= S_ADDR;
        end
        S_DIV: begin
          // reduce both coordinates by repeated subtraction
          if (row_c >= rows) row_c <= row_c - rows;
          if (col_c >= cols) col_c <= col_c - cols;
          if (row_c < rows && col_c < cols) state <= S_DONE;
        end
        S_ADDR: begin
          base   <= AW'(32'(pgr) * 32'(stride));
          rowoff <= SW'(wrow) * SW'(cols);
          state  <= S_CELL;
        end
        S_CELL: begin
          cnt <= '0;
          if (k == tcon_pkg::KIND_TTY && row_c >= rows && rows > 8'd1) begin
            state <= S_SCROLL;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCROLL: begin
          if (cnt == copy_len) begin
            state <= S_BLANK;
          end else begin
            cnt <= cnt + SW'(1);
          end
        end
        S_BLANK: begin
          if (cnt == stride - SW'(1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + SW'(1);
          end
        end
        S_DONE: begin
          page_out <= shown_page;
          case (k)
            tcon_pkg::KIND_TTY: begin
              cur_rows[pidx] <= row_fin;
              cur_cols[pidx] <= col_c;
              cursor_row_out <= row_fin;
              cursor_col_out <= col_c;
              glyph_out      <= gl;
              attr_out       <= '0;
            end
            tcon_pkg::KIND_SETC: begin
              cur_rows[pidx] <= row_c;
              cur_cols[pidx] <= col_c;
              cursor_row_out <= row_c;
              cursor_col_out <= col_c;
              glyph_out      <= '0;
              attr_out       <= '0;
            end
            tcon_pkg::KIND_READ: begin
              cursor_row_out <= st_row;
              cursor_col_out <= st_col;
              glyph_out      <= mem_rdata[7:0];
              attr_out       <= mem_rdata[15:8];
            end
            default: begin
              cursor_row_out <= st_row;
              cursor_col_out <= st_col;
              glyph_out      <= '0;
              attr_out       <= '0;
            end
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // an accepted request always raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // no result while the cell store is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing pass");

  // reported page always exists
  a_page_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(page_out) < PAGES))
    else $error("page out of range");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the text console teletype: directed and random requests,
// register writes over the APB port, results checked against an internal model.
// Depends on tcon_pkg and the text_console_teletype RTL.
module testbench;

  localparam int NPAGE = 8;
  localparam int NCOLS = 128;
  localparam int NROWS = 32;
  localparam int DEPTH = NPAGE * NROWS * NCOLS;
  localparam int WATCH_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [2:0] page;
    logic [7:0] glyph;
    logic [7:0] attr;
  } cursor_report_t;

  // Scoreboard: holds predicted cursor reports and checks each strobed result.
  class console_board;
    cursor_report_t pending[$];
    int mismatches;
    int checked;

    function void note_request(cursor_report_t exp_rep);
      pending.push_back(exp_rep);
    endfunction

    function void check_report(cursor_report_t got);
      cursor_report_t exp_rep;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_rep = pending.pop_front();
      checked++;
      if (exp_rep !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp r%0d c%0d p%0d g%h a%h, got r%0d c%0d p%0d g%h a%h",
                   exp_rep.row, exp_rep.col, exp_rep.page, exp_rep.glyph, exp_rep.attr,
                   got.row, got.col, got.page, got.glyph, got.attr);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic busy, done, pready;
  logic [1:0] kind = 0;
  logic [7:0] glyph = 0, attr_in = 0, row_req = 0, col_req = 0;
  logic [2:0] page_sel = 0;
  logic [7:0] cursor_row_out, cursor_col_out, glyph_out, attr_out;
  logic [2:0] page_out;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  text_console_teletype dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Model state of the console.
  logic [15:0] cells[DEPTH];
  logic [7:0] cur_row[NPAGE], cur_col[NPAGE], pg_attr[NPAGE];
  logic [2:0] act_page;
  logic [7:0] reg_cols, reg_rows;
  console_board board = new();
  int idle_cycles;
  bit timed_out;

  function automatic int eff_cols();
    int c = reg_cols;
    if (c == 0) c = 80;
    if (c > NCOLS) c = NCOLS;
    return c;
  endfunction

  function automatic int eff_rows();
    int r = reg_rows;
    if (r == 0) r = 25;
    if (r > NROWS) r = NROWS;
    return r;
  endfunction

  function automatic int cell_at(int pg, int r, int c);
    return pg * eff_rows() * eff_cols() + r * eff_cols() + c;
  endfunction

  function automatic void poke(int pg, int r, int c, logic [15:0] v);
    int i = cell_at(pg, r, c);
    if (i < DEPTH) cells[i] = v;
  endfunction

  function automatic logic [15:0] peek(int pg, int r, int c);
    int i = cell_at(pg, r, c);
    return (i < DEPTH) ? cells[i] : 16'h0;
  endfunction

  // Advance the model by one request and return the expected report.
  function automatic cursor_report_t console_step(logic [1:0] k, logic [7:0] g,
                                                  logic [2:0] ps, logic [7:0] a,
                                                  logic [7:0] rr, logic [7:0] cr);
    int rows = eff_rows(), cols = eff_cols();
    int pg = ps, r, c;
    logic [15:0] v;
    cursor_report_t rep = '0;
    if (k == tcon_pkg::KIND_TTY) begin
      act_page = ps;
      r = (cur_row[pg] >= rows) ? rows - 1 : cur_row[pg];
      c = (cur_col[pg] >= cols) ? cols - 1 : cur_col[pg];
      if (g == tcon_pkg::CH_CR) c = 0;
      else if (g == tcon_pkg::CH_LF) r++;
      else if (g == tcon_pkg::CH_BS) begin
        if (c > 0) c--;
        else if (r > 0) begin
          r--;
          c = cols - 1;
        end
        poke(pg, r, c, {pg_attr[pg], tcon_pkg::CH_BLANK});
      end else begin
        pg_attr[pg] = a;
        poke(pg, r, c, {a, g});
        c++;
        if (c >= cols) begin
          c = 0;
          r++;
        end
      end
      if (r >= rows) begin
        // scroll up one line, blank the bottom line
        if (rows > 1) begin
          for (int y = 0; y + 1 < rows; y++)
            for (int x = 0; x < cols; x++) poke(pg, y, x, peek(pg, y + 1, x));
          for (int x = 0; x < cols; x++)
            poke(pg, rows - 1, x, {pg_attr[pg], tcon_pkg::CH_BLANK});
        end
        r = rows - 1;
      end
      cur_row[pg] = 8'(r);
      cur_col[pg] = 8'(c);
      rep.glyph = g;
    end else if (k == tcon_pkg::KIND_SETC) begin
      act_page = ps;
      cur_row[pg] = 8'(32'(rr) % rows);
      cur_col[pg] = 8'(32'(cr) % cols);
    end else begin
      pg = act_page;
      if (k == tcon_pkg::KIND_READ) begin
        r = (cur_row[pg] >= rows) ? rows - 1 : cur_row[pg];
        c = (cur_col[pg] >= cols) ? cols - 1 : cur_col[pg];
        v = peek(pg, r, c);
        rep.glyph = v[7:0];
        rep.attr = v[15:8];
      end
    end
    rep.row = cur_row[pg];
    rep.col = cur_col[pg];
    rep.page = act_page;
    return rep;
  endfunction

  // Check every result strobe at the rising edge; watchdog counts quiet cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        board.check_report({cursor_row_out, cursor_col_out, page_out, glyph_out, attr_out});
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
        $display("watchdog expired");
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Issue one request: hold start until accepted, then drop it.
  task automatic send_request(logic [1:0] k, logic [7:0] g, logic [2:0] ps,
                              logic [7:0] a, logic [7:0] rr, logic [7:0] cr);
    kind <= k; glyph <= g; page_sel <= ps; attr_in <= a; row_req <= rr; col_req <= cr;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(console_step(k, g, ps, a, rr, cr));
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait until every result has arrived, then let a little latency pass.
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Write a size register while the block is idle.
  task automatic write_reg(logic reg_sel, logic [7:0] value);
    drain();
    paddr <= {reg_sel, 2'b00};
    pwdata <= {24'd0, value};
    pwrite <= 1;
    psel <= 1;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (reg_sel == tcon_pkg::REG_COLS) reg_cols = value;
    else reg_rows = value & 8'h3F;
  endtask

  // Bursty random traffic; mostly printable text with some control codes.
  task automatic random_phase(int count);
    int burst = 0;
    logic [1:0] k;
    logic [7:0] g;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      burst--;
      case ($urandom_range(0, 9))
        0, 1: k = tcon_pkg::KIND_READ;
        2: k = tcon_pkg::KIND_SETC;
        3: k = tcon_pkg::KIND_SPARE;
        default: k = tcon_pkg::KIND_TTY;
      endcase
      case ($urandom_range(0, 7))
        0: g = tcon_pkg::CH_CR;
        1: g = tcon_pkg::CH_LF;
        2: g = tcon_pkg::CH_BS;
        default: g = 8'($urandom_range(0, 255));
      endcase
      send_request(k, g, $urandom_range(0, 1) ? 3'($urandom_range(0, 7)) : act_page,
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    foreach (cells[i]) cells[i] = 0;
    for (int p = 0; p < NPAGE; p++) begin
      cur_row[p] = 0; cur_col[p] = 0; pg_attr[p] = 0;
    end
    act_page = 0; reg_cols = tcon_pkg::DEF_COLS; reg_rows = tcon_pkg::DEF_ROWS;
    idle_cycles = 0;
    repeat (7) @(negedge clk);
    rst <= 0;

    // Directed: tiny screen to exercise wrap, scroll and backspace at origin.
    write_reg(tcon_pkg::REG_COLS, 8'd4);
    write_reg(tcon_pkg::REG_ROWS, 8'd3);
    send_request(tcon_pkg::KIND_TTY, tcon_pkg::CH_BS, 3'd0, 8'h00, 8'd0, 8'd0);
    send_request(tcon_pkg::KIND_READ, 8'd0, 3'd0, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 14; i++)
      send_request(tcon_pkg::KIND_TTY, 8'(8'h41 + i), 3'd2, 8'(8'h17 + i), 8'd0, 8'd0);
    send_request(tcon_pkg::KIND_TTY, tcon_pkg::CH_LF, 3'd2, 8'd0, 8'd0, 8'd0);
    send_request(tcon_pkg::KIND_TTY, tcon_pkg::CH_CR, 3'd2, 8'd0, 8'd0, 8'd0);
    send_request(tcon_pkg::KIND_TTY, tcon_pkg::CH_BS, 3'd2, 8'd0, 8'd0, 8'd0);
    send_request(tcon_pkg::KIND_SETC, 8'd0, 3'd7, 8'd0, 8'hFF, 8'hFF);
    send_request(tcon_pkg::KIND_TTY, 8'hFF, 3'd7, 8'hFF, 8'd0, 8'd0);
    send_request(tcon_pkg::KIND_SPARE, 8'd0, 3'd5, 8'd0, 8'd0, 8'd0);
    send_request(tcon_pkg::KIND_SETC, 8'd0, 3'd2, 8'd0, 8'd1, 8'd2);
    send_request(tcon_pkg::KIND_READ, 8'd0, 3'd4, 8'd0, 8'd0, 8'd0);

    // Single row, then stale cursors after shrinking and extremes.
    write_reg(tcon_pkg::REG_ROWS, 8'd1);
    send_request(tcon_pkg::KIND_TTY, tcon_pkg::CH_LF, 3'd2, 8'd0, 8'd0, 8'd0);
    random_phase(30);
    write_reg(tcon_pkg::REG_COLS, 8'd1);
    write_reg(tcon_pkg::REG_ROWS, 8'd2);
    random_phase(30);
    write_reg(tcon_pkg::REG_COLS, 8'd0);
    write_reg(tcon_pkg::REG_ROWS, 8'd0);
    random_phase(40);
    write_reg(tcon_pkg::REG_COLS, 8'd255);
    write_reg(tcon_pkg::REG_ROWS, 8'd63);
    random_phase(30);
    write_reg(tcon_pkg::REG_COLS, 8'd7);
    write_reg(tcon_pkg::REG_ROWS, 8'd5);
    random_phase(70);

    drain();
    $display("covered %0d results over several screen sizes, scrolls and control codes",
             board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

>>> text_console_teletype.f
sv/tcon_pkg.sv
sv/tcon_cell_mem.sv
sv/text_console_teletype.sv
bench/testbench.sv
